// File: rtl/html_tag_stripper_assert.svh
// assertion macros shared by the stripper modules
`ifndef HTML_TAG_STRIPPER_ASSERT_SVH
`define HTML_TAG_STRIPPER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HTS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("html_tag_stripper check failed");

// next-cycle implication, checked out of reset
`define HTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("html_tag_stripper check failed");

`endif

// File: rtl/hts_pkg.sv
package hts_pkg;

    // command from the front classifier to the back emitter
    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_TEXT    = 2'd1,
        CMD_SPACE   = 2'd2,
        CMD_NEWLINE = 2'd3
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] data;
        logic       last;
    } cmd_t;

    // command queue geometry
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = 2;
    localparam int CMD_CNT_W = 3;

    // special bytes
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // block-level tag names
    localparam int NUM_NAMES   = 22;
    localparam int NAME_MAXLEN = 7;
    localparam int NAME_IDX_W  = 5;

    localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{
        3'd2, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd5, 3'd3, 3'd3,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd3, 3'd6, 3'd7, 3'd4, 3'd7, 3'd7, 3'd2
    };

    // right-justified in 56 bits, first character highest
    localparam logic [NAME_MAXLEN*8-1:0] NAME_STR [NUM_NAMES] = '{
        56'("br"), 56'("p"), 56'("h1"), 56'("h2"), 56'("h3"), 56'("h4"),
        56'("h5"), 56'("h6"), 56'("title"), 56'("div"), 56'("pre"),
        56'("table"), 56'("tbody"), 56'("thead"), 56'("tfoot"), 56'("img"),
        56'("figure"), 56'("address"), 56'("form"), 56'("section"),
        56'("article"), 56'("li")
    };

    // character at position pos of a name, pos must be below its length
    function automatic logic [7:0] name_char(logic [NAME_IDX_W-1:0] idx, logic [2:0] pos);
        logic [2:0] shift;
        shift = NAME_LEN[idx] - 3'd1 - pos;
        return NAME_STR[idx][8*shift +: 8];
    endfunction

endpackage

// File: rtl/hts_front.sv
module hts_front #(
    parameter int MAX_PREFIX = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_in_byte,
    input  logic             s_end_of_text,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output hts_pkg::cmd_t    cmd
);
    import hts_pkg::*;

    localparam int NAME_CAP = MAX_PREFIX - 1;
    localparam int LEN_W    = $clog2(MAX_PREFIX);

    logic                 inside_reg, inside_next;
    logic                 match_reg, match_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [NUM_NAMES-1:0] alive_reg, alive_next;

    logic                 accept;
    logic                 is_ws;
    logic [31:0]          len_ext;
    logic [2:0]           pos;
    logic                 pos_ok;
    logic [NUM_NAMES-1:0] init_mask;
    logic [NUM_NAMES-1:0] alive_hit;
    logic [NUM_NAMES-1:0] full_hit;
    logic [NUM_NAMES-1:0] part_hit;
    cmd_op_t              op;

    assign s_ready = cmd_ready;
    assign accept  = s_valid && s_ready;

    // position of the next name byte
    assign len_ext = 32'(len_reg);
    assign pos_ok  = len_ext < NAME_MAXLEN;
    assign pos     = len_ext[2:0];

    // per-name prefix compare on the incoming byte
    always_comb begin
        for (int i = 0; i < NUM_NAMES; i++) begin
            init_mask[i] = 32'(NAME_LEN[i]) <= NAME_CAP;
            alive_hit[i] = alive_reg[i] && pos_ok && (NAME_LEN[i] > pos) &&
                           (name_char(NAME_IDX_W'(i), pos) == s_in_byte);
            full_hit[i]  = alive_hit[i] && ({1'b0, NAME_LEN[i]} == ({1'b0, pos} + 4'd1));
            part_hit[i]  = alive_hit[i] && ({1'b0, NAME_LEN[i]} > ({1'b0, pos} + 4'd1));
        end
    end

    assign is_ws = s_in_byte inside {CH_SPACE, [8'd9:8'd13]};

    // classify the byte and advance the tag state
    always_comb begin
        inside_next = inside_reg;
        match_next  = match_reg;
        len_next    = len_reg;
        alive_next  = alive_reg;
        op          = CMD_NONE;
        if (s_in_byte == CH_LT) begin
            inside_next = 1'b1;
            match_next  = 1'b1;
            len_next    = '0;
            alive_next  = init_mask;
        end else if (s_in_byte == CH_GT) begin
            inside_next = 1'b0;
            match_next  = 1'b0;
        end else if (match_reg) begin
            if (len_ext >= NAME_CAP) begin
                match_next = 1'b0;
            end else begin
                len_next   = len_reg + 1'b1;
                alive_next = alive_hit;
                if (|full_hit) begin
                    match_next = 1'b0;
                    op         = CMD_NEWLINE;
                end else if (!(|part_hit)) begin
                    match_next = 1'b0;
                end
            end
        end else if (!inside_reg) begin
            op = is_ws ? CMD_SPACE : CMD_TEXT;
        end
        if (s_end_of_text) begin
            inside_next = 1'b0;
            match_next  = 1'b0;
            len_next    = '0;
        end
    end

    // only transactions that matter to the back end are queued
    assign cmd.op    = op;
    assign cmd.data  = s_in_byte;
    assign cmd.last  = s_end_of_text;
    assign cmd_valid = s_valid && ((op != CMD_NONE) || s_end_of_text);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg <= 1'b0;
            match_reg  <= 1'b0;
            len_reg    <= '0;
            alive_reg  <= '0;
        end else if (accept) begin
            inside_reg <= inside_next;
            match_reg  <= match_next;
            len_reg    <= len_next;
            alive_reg  <= alive_next;
        end
    end

endmodule

// File: rtl/hts_cmd_fifo.sv
`include "html_tag_stripper_assert.svh"

module hts_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  hts_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop,
    output hts_pkg::cmd_t pop_cmd
);
    import hts_pkg::*;

    cmd_t                 entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CMD_CNT_W-1:0] count_reg, count_next;
    logic                 do_push, do_pop;

    assign push_ready = count_reg != CMD_CNT_W'(CMD_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `HTS_ASSERT_NOW(a_fill_bounded, aclk, aresetn, 1'b1, count_reg <= CMD_CNT_W'(CMD_DEPTH))
    `HTS_ASSERT_NOW(a_ptr_gap, aclk, aresetn, (count_reg == '0) || (count_reg == CMD_CNT_W'(CMD_DEPTH)), wr_ptr_reg == rd_ptr_reg)

endmodule

// File: rtl/hts_back.sv
`include "html_tag_stripper_assert.svh"

module hts_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_wr_data,
    input  logic          cmd_valid,
    output logic          cmd_pop,
    input  hts_pkg::cmd_t cmd,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_has_byte,
    output logic          m_last_out
);
    import hts_pkg::*;

    logic [1:0] limit_reg;
    logic       after_space_reg, after_space_next;
    logic [1:0] nl_count_reg, nl_count_next;
    logic       held_reg, held_next;
    logic       m_valid_reg;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       has_byte_reg, has_byte_next;
    logic       last_reg, last_next;

    logic       out_free;
    logic       emits;
    logic       need_out;
    logic       advance;
    logic       load;

    assign out_free = !m_valid_reg || m_ready;
    assign emits    = (cmd.op == CMD_TEXT) ||
                      ((cmd.op == CMD_NEWLINE) && (nl_count_reg < limit_reg));
    assign need_out = emits || cmd.last;
    assign advance  = cmd_valid && (!need_out || out_free);
    assign load     = advance && need_out;
    // a held space goes out first and keeps the command at the head
    assign cmd_pop  = advance && !(emits && held_reg);

    // text state and the next result
    always_comb begin
        after_space_next = after_space_reg;
        nl_count_next    = nl_count_reg;
        held_next        = held_reg;
        out_byte_next    = '0;
        has_byte_next    = 1'b0;
        last_next        = cmd.last;
        if (emits && held_reg) begin
            out_byte_next = CH_SPACE;
            has_byte_next = 1'b1;
            last_next     = 1'b0;
            held_next     = 1'b0;
        end else if (emits) begin
            has_byte_next = 1'b1;
            if (cmd.op == CMD_NEWLINE) begin
                out_byte_next = CH_LF;
                nl_count_next = nl_count_reg + 2'd1;
            end else begin
                out_byte_next    = cmd.data;
                after_space_next = 1'b0;
            end
        end else if ((cmd.op == CMD_SPACE) && !after_space_reg) begin
            held_next        = 1'b1;
            after_space_next = 1'b1;
            nl_count_next    = '0;
        end
        if (cmd.last && cmd_pop) begin
            after_space_next = 1'b1;
            nl_count_next    = '0;
            held_next        = 1'b0;
        end
    end

    // newline limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 2'd2;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // text state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            after_space_reg <= 1'b1;
            nl_count_reg    <= '0;
            held_reg        <= 1'b0;
        end else if (advance) begin
            after_space_reg <= after_space_next;
            nl_count_reg    <= nl_count_next;
            held_reg        <= held_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_byte_reg <= out_byte_next;
            has_byte_reg <= has_byte_next;
            last_reg     <= last_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_has_byte = has_byte_reg;
    assign m_last_out = last_reg;

    `HTS_ASSERT_NOW(a_bare_is_last, aclk, aresetn, m_valid_reg && !has_byte_reg, last_reg)
    `HTS_ASSERT_NOW(a_space_not_last, aclk, aresetn, m_valid_reg && has_byte_reg && (out_byte_reg == CH_SPACE), !last_reg)
    `HTS_ASSERT_NEXT(a_doc_end_clears, aclk, aresetn, load && cmd.last && cmd_pop, after_space_reg && !held_reg && (nl_count_reg == 2'd0))

endmodule

// File: rtl/html_tag_stripper.sv
// channel   | handshake          | payload
// ----------+--------------------+--------------------------------------
// input     | s_valid / s_ready  | s_in_byte, s_end_of_text
// result    | m_valid / m_ready  | m_out_byte, m_has_byte, m_last_out
// config    | cfg_wr_en          | cfg_wr_data (newline_limit)
//
// one byte accepted per cycle while the 4-entry command queue has room
// results leave at one per cycle while m_ready is high; a byte that releases a held space yields two results
// result valid after its input transaction has passed through the queue and then the output register
// front and back stall independently; the queue absorbs result-side backpressure
// reset is synchronous; newline_limit returns to 2
module html_tag_stripper #(
    parameter int MAX_PREFIX = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_text,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_has_byte,
    output logic       m_last_out
);
    import hts_pkg::*;

    logic push_valid, push_ready;
    cmd_t push_cmd;
    logic head_valid, head_pop;
    cmd_t head_cmd;

    // tag tracking and name matching
    hts_front #(
        .MAX_PREFIX (MAX_PREFIX)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_end_of_text (s_end_of_text),
        .cmd_valid     (push_valid),
        .cmd_ready     (push_ready),
        .cmd           (push_cmd)
    );

    // decoupling queue
    hts_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (head_valid),
        .pop        (head_pop),
        .pop_cmd    (head_cmd)
    );

    // spacing, newline limit and result output
    hts_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (head_valid),
        .cmd_pop     (head_pop),
        .cmd         (head_cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_has_byte  (m_has_byte),
        .m_last_out  (m_last_out)
    );

endmodule

// File: sim/tb_html_tag_stripper.sv
module tb_html_tag_stripper;
    import hts_pkg::*;

    // one result transaction as the block should present it
    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       last;
    } text_out_t;

    // one row of the directed table, with up to two typed-in results
    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       typed;
        logic [1:0] n;
        text_out_t  r0;
        text_out_t  r1;
    } dir_row_t;

    localparam int        PREFIX_MAX   = 8;
    localparam int        NAME_SLOTS   = PREFIX_MAX - 1;
    localparam int        RANDOM_ITEMS = 1550;
    localparam int        CFG_SPACING  = 250;
    localparam int        NUM_CFG      = 6;
    localparam int        HOLD_CYCLES  = 300;
    localparam int        DRAIN_CYCLES = 10;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam text_out_t NO_TEXT      = '0;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       cfg_wr_en     = 1'b0;
    logic [1:0] cfg_wr_data   = 2'd0;
    logic       s_valid       = 1'b0;
    logic [7:0] s_in_byte     = 8'h00;
    logic       s_end_of_text = 1'b0;
    logic       m_ready       = 1'b0;
    wire        s_ready;
    wire        m_valid;
    wire  [7:0] m_out_byte;
    wire        m_has_byte;
    wire        m_last_out;

    html_tag_stripper #(.MAX_PREFIX(PREFIX_MAX)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_has_byte    (m_has_byte),
        .m_last_out    (m_last_out)
    );

    // 12 time unit clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // block-level tag names that start a new line
    string blk_tags [22] = '{
        "br", "p", "h1", "h2", "h3", "h4", "h5", "h6", "title", "div", "pre",
        "table", "tbody", "thead", "tfoot", "img", "figure", "address", "form",
        "section", "article", "li"
    };

    // expected text stream and scratch for one input transaction
    text_out_t  text_expect_q [$];
    text_out_t  step_out [$];
    logic [7:0] doc_q [$];
    dir_row_t   dir_tab [$];

    // stripper state mirrored by the predictor
    logic [1:0] ex_nl_limit;
    logic       ex_in_tag;
    logic       ex_after_space;
    logic [1:0] ex_nl_count;
    logic       ex_held_space;
    logic [7:0] ex_name_buf [NAME_SLOTS];
    int         ex_name_len;
    logic       ex_name_live;

    // run statistics
    int    items_sent   = 0;
    int    docs_sent    = 0;
    int    results_seen = 0;
    int    lf_seen      = 0;
    int    bare_seen    = 0;
    int    mismatches   = 0;
    int    holds_done   = 0;
    string limits_used  = "2";

    function automatic text_out_t txt(logic [7:0] ch, logic has, logic last);
        return {ch, has, last};
    endfunction

    function automatic dir_row_t drow(logic [7:0] ch, logic eot, logic typed, logic [1:0] n,
                                      text_out_t r0, text_out_t r1);
        return {ch, eot, typed, n, r0, r1};
    endfunction

    // ---------------- text predictor ----------------

    function automatic void clear_text_state();
        ex_in_tag      = 1'b0;
        ex_after_space = 1'b1;
        ex_nl_count    = 2'd0;
        ex_held_space  = 1'b0;
        for (int k = 0; k < NAME_SLOTS; k++) ex_name_buf[k] = 8'h00;
        ex_name_len    = 0;
        ex_name_live   = 1'b0;
    endfunction

    function automatic void push_text(logic [7:0] ch, logic has);
        step_out.push_back(txt(ch, has, 1'b0));
    endfunction

    // a held space goes out ahead of the byte that releases it
    function automatic void emit_text(logic [7:0] ch);
        if (ex_held_space) begin
            push_text(CH_SPACE, 1'b1);
            ex_held_space = 1'b0;
        end
        push_text(ch, 1'b1);
    endfunction

    // collect one tag-name byte and decide the block-level prefix match
    function automatic void match_name_byte(logic [7:0] ch);
        bit full;
        bit partial;
        bit same;
        int len;
        full    = 1'b0;
        partial = 1'b0;
        if (ex_name_len >= NAME_SLOTS) begin
            ex_name_live = 1'b0;
            return;
        end
        ex_name_buf[ex_name_len] = ch;
        ex_name_len++;
        foreach (blk_tags[i]) begin
            len = blk_tags[i].len();
            if (len <= NAME_SLOTS && len >= ex_name_len) begin
                same = 1'b1;
                for (int k = 0; k < ex_name_len; k++)
                    if (blk_tags[i][k] != ex_name_buf[k]) same = 1'b0;
                if (same && len == ex_name_len) full = 1'b1;
                else if (same) partial = 1'b1;
            end
        end
        if (full) begin
            ex_name_live = 1'b0;
            if (ex_nl_count < ex_nl_limit) begin
                emit_text(CH_LF);
                ex_nl_count = ex_nl_count + 2'd1;
            end
        end else if (!partial) begin
            ex_name_live = 1'b0;
        end
    endfunction

    // results caused by one input transaction, left in step_out
    function automatic void predict_text(logic [7:0] ch, logic eot);
        text_out_t tail;
        step_out.delete();
        if (ch == CH_LT) begin
            ex_in_tag    = 1'b1;
            ex_name_live = 1'b1;
            ex_name_len  = 0;
        end else if (ch == CH_GT) begin
            ex_in_tag    = 1'b0;
            ex_name_live = 1'b0;
        end else if (ex_name_live) begin
            match_name_byte(ch);
        end else if (!ex_in_tag) begin
            if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
                if (!ex_after_space) begin
                    ex_held_space  = 1'b1;
                    ex_after_space = 1'b1;
                    ex_nl_count    = 2'd0;
                end
            end else begin
                emit_text(ch);
                ex_after_space = 1'b0;
            end
        end
        // end of document: drop the held space, mark the last result
        if (eot) begin
            if (step_out.size() == 0) push_text(CH_NUL, 1'b0);
            tail = step_out[step_out.size() - 1];
            tail.last = 1'b1;
            step_out[step_out.size() - 1] = tail;
            clear_text_state();
        end
    endfunction

    // ---------------- traffic shaping ----------------

    // no idling on either side over one stretch of the run
    function automatic bit roll_idle();
        if (items_sent >= 200 && items_sent < 450) return 1'b0;
        return $urandom_range(0, 99) < 21;
    endfunction

    // one input transaction, with random idle cycles ahead of it
    task automatic offer_byte(input logic [7:0] ch, input logic eot);
        while (roll_idle()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_in_byte     <= ch;
        s_end_of_text <= eot;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        predict_text(ch, eot);
    endtask

    // stop offering and let every expected result and trailing work drain
    task automatic drain_results();
        s_valid <= 1'b0;
        while (text_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        ex_nl_limit = value;
        limits_used = $sformatf("%s,%0d", limits_used, value);
    endtask

    // ---------------- random documents ----------------

    function automatic void push_str(string str);
        for (int k = 0; k < str.len(); k++) doc_q.push_back(str[k]);
    endfunction

    // block names, near misses, wrong case, long and random names
    function automatic string tag_name();
        string nm;
        int    pick;
        int    n;
        pick = $urandom_range(0, 99);
        nm   = blk_tags[$urandom_range(0, 21)];
        if (pick < 15) begin
            if (nm.len() > 1) nm = nm.substr(0, nm.len() - 2);
        end else if (pick < 30) begin
            nm = $sformatf("%s%c", nm, 8'h61 + $urandom_range(0, 25));
        end else if (pick < 40) begin
            nm = nm.toupper();
        end else if (pick < 62) begin
            nm = "";
            n  = $urandom_range(1, 9);
            repeat (n) nm = $sformatf("%s%c", nm, 8'h61 + $urandom_range(0, 25));
        end else if (pick < 72) begin
            nm = $sformatf("h%0d", $urandom_range(0, 9));
        end
        return nm;
    endfunction

    // mostly well-formed markup with random content, plus some noise
    task automatic build_document();
        int parts;
        int pick;
        int n;
        doc_q.delete();
        parts = $urandom_range(3, 14);
        repeat (parts) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                // word of text, now and then a raw byte
                n = $urandom_range(1, 6);
                repeat (n) begin
                    if ($urandom_range(0, 99) < 85)
                        doc_q.push_back(8'h41 + 8'($urandom_range(0, 57)));
                    else
                        doc_q.push_back(8'($urandom_range(0, 255)));
                end
            end else if (pick < 55) begin
                // run of whitespace
                n = $urandom_range(1, 3);
                repeat (n) begin
                    pick = $urandom_range(0, 5);
                    doc_q.push_back(pick == 5 ? CH_SPACE : CH_TAB + 8'(pick));
                end
            end else if (pick < 90) begin
                // tag, sometimes nested, with attributes, sometimes left open
                doc_q.push_back(CH_LT);
                push_str(tag_name());
                if ($urandom_range(0, 99) < 10) begin
                    doc_q.push_back(CH_LT);
                    push_str(tag_name());
                end
                if ($urandom_range(0, 99) < 35) push_str(" class=\"a b\"");
                if ($urandom_range(0, 99) < 92) doc_q.push_back(CH_GT);
            end else begin
                // noise, stray closing brackets among it
                n = $urandom_range(1, 3);
                repeat (n)
                    doc_q.push_back($urandom_range(0, 3) == 0 ? CH_GT
                                                              : 8'($urandom_range(0, 255)));
            end
        end
        if (doc_q.size() == 0) doc_q.push_back(CH_SPACE);
    endtask

    // ---------------- stimulus ----------------

    initial begin : stimulus
        dir_row_t   row;
        logic [1:0] cfg_plan [NUM_CFG];
        int         cfg_step;
        int         rand_start;

        cfg_plan = '{2'd3, 2'd0, 2'd1, 2'd3, 2'd2, 2'd0};

        // directed table, newline_limit at its reset value of 2
        dir_tab.push_back(drow("A",      1'b0, 1'b1, 2'd1, txt("A", 1'b1, 1'b0), NO_TEXT));
        dir_tab.push_back(drow(CH_NUL,   1'b0, 1'b1, 2'd1, txt(CH_NUL, 1'b1, 1'b0), NO_TEXT));
        dir_tab.push_back(drow(8'hFF,    1'b0, 1'b1, 2'd1, txt(8'hFF, 1'b1, 1'b0), NO_TEXT));
        dir_tab.push_back(drow(CH_SPACE, 1'b0, 1'b1, 2'd0, NO_TEXT, NO_TEXT));
        dir_tab.push_back(drow(CH_CR,    1'b0, 1'b1, 2'd0, NO_TEXT, NO_TEXT));
        dir_tab.push_back(drow(CH_LT,    1'b0, 1'b1, 2'd0, NO_TEXT, NO_TEXT));
        dir_tab.push_back(drow("p",      1'b0, 1'b0, 2'd0, NO_TEXT, NO_TEXT));
        dir_tab.push_back(drow(CH_GT,    1'b0, 1'b0, 2'd0, NO_TEXT, NO_TEXT));
        dir_tab.push_back(drow(CH_LT,    1'b0, 1'b0, 2'd0, NO_TEXT, NO_TEXT));
        dir_tab.push_back(drow("b",      1'b0, 1'b0, 2'd0, NO_TEXT, NO_TEXT));
        dir_tab.push_back(drow("r",      1'b0, 1'b0, 2'd0, NO_TEXT, NO_TEXT));
        dir_tab.push_back(drow(CH_LT,    1'b0, 1'b0, 2'd0, NO_TEXT, NO_TEXT));
        dir_tab.push_back(drow("d",      1'b0, 1'b0, 2'd0, NO_TEXT, NO_TEXT));
        dir_tab.push_back(drow(CH_LT,    1'b0, 1'b0, 2'd0, NO_TEXT, NO_TEXT));
        dir_tab.push_back(drow("l",      1'b0, 1'b0, 2'd0, NO_TEXT, NO_TEXT));
        dir_tab.push_back(drow("i",      1'b0, 1'b0, 2'd0, NO_TEXT, NO_TEXT));
        dir_tab.push_back(drow(CH_GT,    1'b0, 1'b0, 2'd0, NO_TEXT, NO_TEXT));
        dir_tab.push_back(drow("x",      1'b1, 1'b0, 2'd0, NO_TEXT, NO_TEXT));
        dir_tab.push_back(drow(CH_LT,    1'b1, 1'b1, 2'd1, txt(CH_NUL, 1'b0, 1'b1), NO_TEXT));
        dir_tab.push_back(drow(CH_SPACE, 1'b0, 1'b1, 2'd0, NO_TEXT, NO_TEXT));
        dir_tab.push_back(drow("q",      1'b0, 1'b1, 2'd1, txt("q", 1'b1, 1'b0), NO_TEXT));
        dir_tab.push_back(drow(CH_SPACE, 1'b1, 1'b1, 2'd1, txt(CH_NUL, 1'b0, 1'b1), NO_TEXT));
        dir_tab.push_back(drow(CH_GT,    1'b1, 1'b1, 2'd1, txt(CH_NUL, 1'b0, 1'b1), NO_TEXT));

        ex_nl_limit = 2'd2;
        clear_text_state();

        // synchronous reset, released once
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows: typed results where given, predictor otherwise
        foreach (dir_tab[i]) begin
            row = dir_tab[i];
            offer_byte(row.ch, row.eot);
            if (row.typed) begin
                if (row.n > 2'd0) text_expect_q.push_back(row.r0);
                if (row.n > 2'd1) text_expect_q.push_back(row.r1);
            end else begin
                foreach (step_out[k]) text_expect_q.push_back(step_out[k]);
            end
        end

        // random documents, newline_limit changed every few hundred transactions
        write_limit(cfg_plan[0]);
        cfg_step   = 1;
        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            build_document();
            docs_sent++;
            foreach (doc_q[k]) begin
                if (cfg_step < NUM_CFG && items_sent - rand_start >= cfg_step * CFG_SPACING) begin
                    write_limit(cfg_plan[cfg_step]);
                    cfg_step++;
                end
                offer_byte(doc_q[k], k == doc_q.size() - 1);
                foreach (step_out[j]) text_expect_q.push_back(step_out[j]);
            end
        end

        drain_results();

        $display("covered %0d input transactions (%0d random documents), %0d results, %0d newlines, %0d bare end markers",
                 items_sent, docs_sent, results_seen, lf_seen, bare_seen);
        $display("newline_limit sequence %s, %0d long receiver hold-offs, %0d mismatches",
                 limits_used, holds_done, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // ---------------- result side ----------------

    // random ready, plus two long hold-offs so the input side backs up
    initial begin : result_side
        @(posedge aclk);
        forever begin
            if ((holds_done == 0 && items_sent >= 700) ||
                (holds_done == 1 && items_sent >= 1300)) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= !roll_idle();
                @(posedge aclk);
            end
        end
    end

    // compare every result transaction with the oldest expectation
    always @(posedge aclk) begin : check_text
        text_out_t want;
        logic      bad;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (text_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: byte %02h has %0b last %0b",
                             m_out_byte, m_has_byte, m_last_out);
            end else begin
                want = text_expect_q.pop_front();
                // the byte field carries nothing on a bare end marker
                bad = (m_has_byte !== want.has) || (m_last_out !== want.last) ||
                      (want.has && m_out_byte !== want.ch);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected byte %02h has %0b last %0b, got byte %02h has %0b last %0b",
                                 want.ch, want.has, want.last, m_out_byte, m_has_byte, m_last_out);
                end
                if (want.has && want.ch == CH_LF) lf_seen++;
                if (!want.has) bare_seen++;
            end
        end
    end

    // watchdog
    initial begin : watchdog
        #(12 * 600000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/hts_pkg.sv
rtl/hts_front.sv
rtl/hts_cmd_fifo.sv
rtl/hts_back.sv
rtl/html_tag_stripper.sv
sim/tb_html_tag_stripper.sv
